// ===== sv/prt_pkg.sv =====
// Package: shared types, codes and helper functions for the packet route table.
`timescale 1ns / 1ps

package prt_pkg;

  localparam int TABLE_SLOTS_DEF = 32;

  localparam int OP_W    = 2;
  localparam int ID_W    = 8;
  localparam int ROUTE_W = 2;
  localparam int SLOT_W  = 5;

  localparam logic [OP_W-1:0] OP_REGISTER = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;
  localparam logic [OP_W-1:0] OP_LOOKUP   = 2'd3;

  localparam logic [ROUTE_W-1:0] ROUTE_CLIENT = 2'd0;
  localparam logic [ROUTE_W-1:0] ROUTE_SERVER = 2'd1;
  localparam logic [ROUTE_W-1:0] ROUTE_BOTH   = 2'd2;
  localparam logic [ROUTE_W-1:0] ROUTE_RSVD   = 2'd3;

  localparam logic [ID_W-1:0] ID_FREE = 8'd0;

  typedef struct packed {
    logic capture;
    logic apply;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_hold;
  } dp_stat_t;

  // Fold the unused route code onto "both".
  function automatic logic [ROUTE_W-1:0] decode_route(input logic [ROUTE_W-1:0] r);
    logic [ROUTE_W-1:0] v;
    v = (r inside {ROUTE_BOTH, ROUTE_RSVD}) ? ROUTE_BOTH : r;
    return v;
  endfunction

  function automatic logic [ROUTE_W-1:0] other_route(input logic [ROUTE_W-1:0] r);
    logic [ROUTE_W-1:0] v;
    v = (r == ROUTE_CLIENT) ? ROUTE_SERVER : ROUTE_CLIENT;
    return v;
  endfunction

endpackage

// ===== sv/prt_ctrl.sv =====
// Controller: sequences capture and apply for each request.
`timescale 1ns / 1ps

module prt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output prt_pkg::ctl_cmd_t cmd,
  input  prt_pkg::dp_stat_t stat
);
  import prt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_APPLY = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.apply   = 1'b0;
    in_stall    = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        // hold until the result register can take the new result
        if (!stat.out_hold) begin
          cmd.apply  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/prt_dpath.sv =====
// Datapath: slot table, parallel id match, slot update and result register.
`timescale 1ns / 1ps

module prt_dpath #(
  parameter int TABLE_SLOTS = prt_pkg::TABLE_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  prt_pkg::ctl_cmd_t            cmd,
  output prt_pkg::dp_stat_t            stat,
  input  logic [prt_pkg::OP_W-1:0]     operation,
  input  logic [prt_pkg::ID_W-1:0]     packet_id,
  input  logic [prt_pkg::ROUTE_W-1:0]  route,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         ok,
  output logic [prt_pkg::ROUTE_W-1:0]  found_route,
  output logic [prt_pkg::SLOT_W-1:0]   found_slot
);
  import prt_pkg::*;

  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  logic [ID_W-1:0]    slot_id    [TABLE_SLOTS];
  logic [ROUTE_W-1:0] slot_route [TABLE_SLOTS];
  logic [ID_W-1:0]    id_next    [TABLE_SLOTS];
  logic [ROUTE_W-1:0] route_next [TABLE_SLOTS];

  logic [OP_W-1:0]        op_q;
  logic [ID_W-1:0]        id_q;
  logic [ROUTE_W-1:0]     rt_q;
  logic [TABLE_SLOTS-1:0] hit_q;
  logic [TABLE_SLOTS-1:0] free_q;

  logic [TABLE_SLOTS-1:0] elig;
  logic [TABLE_SLOTS-1:0] hit_oh;
  logic [TABLE_SLOTS-1:0] free_oh;
  logic [TABLE_SLOTS-1:0] elig_oh;
  logic                   any_hit;
  logic                   any_free;
  logic                   any_elig;
  logic [IDX_W-1:0]       hit_idx;
  logic [ROUTE_W-1:0]     hit_route;

  logic                   ok_next;
  logic [ROUTE_W-1:0]     fr_next;
  logic [SLOT_W-1:0]      fs_next;

  // Match the incoming id against every slot as the request is taken.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q <= operation;
      id_q <= packet_id;
      rt_q <= decode_route(route);
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        hit_q[i]  <= (slot_id[i] == packet_id);
        free_q[i] <= (slot_id[i] == ID_FREE);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      elig[i] = hit_q[i] && (rt_q == ROUTE_BOTH || slot_route[i] == rt_q ||
                             slot_route[i] == ROUTE_BOTH);
    end
  end

  // Isolate the lowest set bit of each match vector.
  assign hit_oh  = hit_q  & (~hit_q  + TABLE_SLOTS'(1));
  assign free_oh = free_q & (~free_q + TABLE_SLOTS'(1));
  assign elig_oh = elig   & (~elig   + TABLE_SLOTS'(1));
  assign any_hit  = |hit_q;
  assign any_free = |free_q;
  assign any_elig = |elig;

  always_comb begin
    hit_idx   = '0;
    hit_route = ROUTE_CLIENT;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (hit_oh[i]) begin
        hit_idx = IDX_W'(i);
      end
      hit_route = hit_route | (slot_route[i] & {ROUTE_W{hit_oh[i]}});
    end
  end

  always_comb begin
    id_next    = slot_id;
    route_next = slot_route;
    ok_next    = 1'b0;
    fr_next    = ROUTE_CLIENT;
    fs_next    = '0;
    case (op_q)
      OP_REGISTER: begin
        if (id_q != ID_FREE) begin
          if (any_hit) begin
            ok_next = 1'b1;
            for (int i = 0; i < TABLE_SLOTS; i++) begin
              if (hit_oh[i] && slot_route[i] != rt_q) begin
                route_next[i] = ROUTE_BOTH;
              end
            end
          end else if (any_free) begin
            ok_next = 1'b1;
            for (int i = 0; i < TABLE_SLOTS; i++) begin
              if (free_oh[i]) begin
                id_next[i]    = id_q;
                route_next[i] = rt_q;
              end
            end
          end
        end
      end
      OP_REMOVE: begin
        ok_next = any_elig;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (elig_oh[i]) begin
            if (rt_q == ROUTE_BOTH || slot_route[i] == rt_q) begin
              id_next[i]    = ID_FREE;
              route_next[i] = ROUTE_CLIENT;
            end else begin
              route_next[i] = other_route(rt_q);
            end
          end
        end
      end
      OP_CLEAR: begin
        ok_next = 1'b1;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (slot_id[i] != ID_FREE) begin
            if (rt_q == ROUTE_BOTH || slot_route[i] == rt_q) begin
              id_next[i]    = ID_FREE;
              route_next[i] = ROUTE_CLIENT;
            end else if (slot_route[i] == ROUTE_BOTH) begin
              route_next[i] = other_route(rt_q);
            end
          end
        end
      end
      OP_LOOKUP: begin
        ok_next = any_hit;
        if (any_hit) begin
          fr_next = hit_route;
          fs_next = SLOT_W'(hit_idx);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        slot_id[i]    <= ID_FREE;
        slot_route[i] <= ROUTE_CLIENT;
      end
    end else if (cmd.apply) begin
      slot_id    <= id_next;
      slot_route <= route_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.apply) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      ok          <= ok_next;
      found_route <= fr_next;
      found_slot  <= fs_next;
    end
  end

  assign stat.out_hold = out_valid && out_stall;

endmodule

// ===== sv/packet_route_table_unit.sv =====
// Top level: packet route table, controller plus datapath.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// request   in         in_valid / in_stall   operation, packet_id, route
// result    out        out_valid / out_stall ok, found_route, found_slot
//
// For each request, the accept edge registers the id match against all
// slots; the apply edge then updates the table and loads the result
// register. The result register lets a new request be taken while the last
// result still waits downstream. If that result is still stalled when the
// next update is due, hold the update until the result register drains.
// Synchronous reset frees every slot (id 0, client route) at once.

module packet_route_table_unit #(
  parameter int TABLE_SLOTS = prt_pkg::TABLE_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [prt_pkg::OP_W-1:0]     operation,
  input  logic [prt_pkg::ID_W-1:0]     packet_id,
  input  logic [prt_pkg::ROUTE_W-1:0]  route,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         ok,
  output logic [prt_pkg::ROUTE_W-1:0]  found_route,
  output logic [prt_pkg::SLOT_W-1:0]   found_slot
);
  import prt_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // Sequence each request: capture on accept, then apply.
  prt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  // Table, match vectors, update rules and result register.
  prt_dpath #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .operation   (operation),
    .packet_id   (packet_id),
    .route       (route),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ok          (ok),
    .found_route (found_route),
    .found_slot  (found_slot)
  );

endmodule

// ===== tb/tb.sv =====
// Testbench for the packet route table: request driver, result monitor and table scoreboard.
`timescale 1ns / 1ps

module tb;
  import prt_pkg::*;

  typedef struct packed {
    logic               ok;
    logic [ROUTE_W-1:0] found_route;
    logic [SLOT_W-1:0]  found_slot;
  } route_result_t;

  // Shadow copy of the route table. Each accepted request updates the copy and
  // queues the result that the block owes for it.
  class route_table_model;
    logic [ID_W-1:0]    slot_id    [TABLE_SLOTS_DEF];
    logic [ROUTE_W-1:0] slot_route [TABLE_SLOTS_DEF];
    route_result_t      owed_results[$];
    int                 mismatches;

    function new();
      foreach (slot_id[i]) begin
        slot_id[i]    = ID_FREE;
        slot_route[i] = ROUTE_CLIENT;
      end
      mismatches = 0;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                               logic [ROUTE_W-1:0] route_code);
      route_result_t      res;
      logic [ROUTE_W-1:0] r;
      logic [ROUTE_W-1:0] split_route;
      logic               done;
      res  = '0;
      done = 1'b0;
      // Fold the spare route code onto both.
      r = (route_code >= ROUTE_BOTH) ? ROUTE_BOTH : route_code;
      split_route = (r == ROUTE_CLIENT) ? ROUTE_SERVER : ROUTE_CLIENT;
      case (op)
        OP_REGISTER: begin
          if (id != ID_FREE) begin
            for (int i = 0; i < TABLE_SLOTS_DEF; i++) begin
              if (!done && slot_id[i] == id) begin
                if (slot_route[i] != r) slot_route[i] = ROUTE_BOTH;
                done = 1'b1;
              end
            end
            for (int i = 0; i < TABLE_SLOTS_DEF; i++) begin
              if (!done && slot_id[i] == ID_FREE) begin
                slot_id[i]    = id;
                slot_route[i] = r;
                done          = 1'b1;
              end
            end
          end
          res.ok = done;
        end
        OP_REMOVE: begin
          for (int i = 0; i < TABLE_SLOTS_DEF; i++) begin
            if (!done && slot_id[i] == id) begin
              if (r == ROUTE_BOTH || slot_route[i] == r) begin
                slot_id[i]    = ID_FREE;
                slot_route[i] = ROUTE_CLIENT;
                done          = 1'b1;
              end else if (slot_route[i] == ROUTE_BOTH) begin
                slot_route[i] = split_route;
                done          = 1'b1;
              end
            end
          end
          res.ok = done;
        end
        OP_CLEAR: begin
          for (int i = 0; i < TABLE_SLOTS_DEF; i++) begin
            if (slot_id[i] != ID_FREE) begin
              if (r == ROUTE_BOTH || slot_route[i] == r) begin
                slot_id[i]    = ID_FREE;
                slot_route[i] = ROUTE_CLIENT;
              end else if (slot_route[i] == ROUTE_BOTH) begin
                slot_route[i] = split_route;
              end
            end
          end
          res.ok = 1'b1;
        end
        default: begin
          for (int i = 0; i < TABLE_SLOTS_DEF; i++) begin
            if (!done && slot_id[i] == id) begin
              res.ok          = 1'b1;
              res.found_route = slot_route[i];
              res.found_slot  = SLOT_W'(i);
              done            = 1'b1;
            end
          end
        end
      endcase
      owed_results.push_back(res);
    endfunction

    function void check_result(logic ok, logic [ROUTE_W-1:0] found_route,
                               logic [SLOT_W-1:0] found_slot);
      route_result_t owed;
      if (owed_results.size() == 0) begin
        $display("%0t: result with no request pending: ok=%0d route=%0d slot=%0d",
                 $time, ok, found_route, found_slot);
        mismatches++;
        return;
      end
      owed = owed_results.pop_front();
      if (ok !== owed.ok) begin
        $display("%0t: ok expected %0d actual %0d", $time, owed.ok, ok);
        mismatches++;
      end
      if (found_route !== owed.found_route) begin
        $display("%0t: found_route expected %0d actual %0d", $time, owed.found_route,
                 found_route);
        mismatches++;
      end
      if (found_slot !== owed.found_slot) begin
        $display("%0t: found_slot expected %0d actual %0d", $time, owed.found_slot,
                 found_slot);
        mismatches++;
      end
    endfunction
  endclass

  // Generous bound: ~550 requests, each with capped sender gaps and random
  // result stalls, stays far below this.
  localparam longint CYCLE_LIMIT = 400000;
  localparam int     POOL_SIZE   = 40;
  localparam int     GAP_CAP     = 30;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [OP_W-1:0]    operation = OP_LOOKUP;
  logic [ID_W-1:0]    packet_id = ID_FREE;
  logic [ROUTE_W-1:0] route     = ROUTE_CLIENT;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               ok;
  logic [ROUTE_W-1:0] found_route;
  logic [SLOT_W-1:0]  found_slot;

  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;
  longint cycles         = 0;
  logic [ID_W-1:0] id_pool [POOL_SIZE];

  route_table_model route_model = new();

  packet_route_table_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .packet_id   (packet_id),
    .route       (route),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ok          (ok),
    .found_route (found_route),
    .found_slot  (found_slot)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run-length guard: end the run if results stop coming.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: decide the stall for the next edge on the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Monitor: take a result on every edge where the block offers one and we
  // do not stall it.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      route_model.check_result(ok, found_route, found_slot);
    end
  end

  // Drive one request. Enter and leave on a falling edge. Hold the payload
  // until the block takes it, then note it with the scoreboard.
  task automatic send_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                              logic [ROUTE_W-1:0] r);
    int gap;
    gap = 0;
    // Idle the request channel for a random stretch before presenting.
    while (gap < GAP_CAP && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      gap++;
    end
    operation <= op;
    packet_id <= id;
    route     <= r;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
    route_model.note_request(op, id, r);
    @(negedge clk);
  endtask

  // Pick an id: mostly from the phase pool so entries get reused, with some
  // free-slot ids and some fully random ones.
  function automatic logic [ID_W-1:0] pick_id();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (sel < 90) return ID_FREE;
    return ID_W'($urandom_range(0, 255));
  endfunction

  // One random phase: refresh the id pool, open with a burst of register
  // requests aimed at filling the table, then mix all operations.
  task automatic run_phase(int n_items, int idle_pct, int stall_pct);
    int sel;
    logic [OP_W-1:0] op;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    foreach (id_pool[i]) id_pool[i] = ID_W'($urandom_range(1, 255));
    for (int n = 0; n < n_items; n++) begin
      sel = $urandom_range(0, 99);
      if (n < POOL_SIZE || sel < 40) op = OP_REGISTER;
      else if (sel < 62)             op = OP_REMOVE;
      else if (sel < 65)             op = OP_CLEAR;
      else                           op = OP_LOOKUP;
      send_request(op, pick_id(), ROUTE_W'($urandom_range(0, 3)));
    end
  endtask

  initial begin
    // Hold reset, then release it on a falling edge.
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed requests, no idling.
    send_request(OP_REGISTER, ID_FREE, ROUTE_CLIENT);  // id zero is refused
    send_request(OP_REGISTER, 8'hFF, ROUTE_CLIENT);
    send_request(OP_REGISTER, 8'hFF, ROUTE_SERVER);    // merge into both
    send_request(OP_REGISTER, 8'h01, ROUTE_RSVD);      // spare code stored as both
    send_request(OP_LOOKUP, 8'hFF, ROUTE_CLIENT);
    send_request(OP_LOOKUP, 8'h01, ROUTE_SERVER);
    send_request(OP_LOOKUP, ID_FREE, ROUTE_CLIENT);    // first free slot
    send_request(OP_REMOVE, 8'hFF, ROUTE_CLIENT);      // split both to server
    send_request(OP_REMOVE, 8'hFF, ROUTE_CLIENT);      // route mismatch, fails
    send_request(OP_REMOVE, 8'hFF, ROUTE_SERVER);      // frees the slot
    send_request(OP_REMOVE, ID_FREE, ROUTE_SERVER);    // free slots are client
    send_request(OP_REMOVE, ID_FREE, ROUTE_CLIENT);
    send_request(OP_REMOVE, ID_FREE, ROUTE_RSVD);
    send_request(OP_LOOKUP, 8'h4D, ROUTE_BOTH);        // miss
    send_request(OP_REMOVE, 8'hAA, ROUTE_BOTH);        // missing id
    send_request(OP_REGISTER, 8'h02, ROUTE_SERVER);
    send_request(OP_REGISTER, 8'h03, ROUTE_BOTH);
    send_request(OP_REGISTER, 8'h80, ROUTE_CLIENT);
    send_request(OP_CLEAR, 8'h00, ROUTE_CLIENT);       // drop client, split both
    send_request(OP_LOOKUP, 8'h03, ROUTE_CLIENT);
    send_request(OP_LOOKUP, 8'h02, ROUTE_CLIENT);
    send_request(OP_CLEAR, 8'hFF, ROUTE_RSVD);         // empty the table
    send_request(OP_LOOKUP, 8'h01, ROUTE_CLIENT);

    // Random phases: free running, sender idle, receiver stalling, both.
    run_phase(132, 0, 0);
    run_phase(132, 63, 0);
    run_phase(132, 0, 63);
    run_phase(132, 12, 12);

    in_valid <= 1'b0;
    // Drain: wait for every owed result, then keep watching for stray results.
    while (route_model.owed_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (route_model.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/prt_pkg.sv
sv/prt_ctrl.sv
sv/prt_dpath.sv
sv/packet_route_table_unit.sv
tb/tb.sv
